### rtl/complex_arithmetic_unit_core_macros.svh
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH

// clocked check, off during reset
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, also active during reset
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cau_pkg.sv
`default_nettype none
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // number of quotient bits produced by the divider pipe
  localparam int QBITS = 32;
  // widest scaled numerator magnitude: 64 bits shifted by up to 30
  localparam int NUM_W = 94;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  // after the multiplier stage
  typedef struct packed {
    op_t                func;
    logic signed [32:0] sum_re;
    logic signed [32:0] sum_im;
    logic signed [63:0] pac;
    logic signed [63:0] pbd;
    logic signed [63:0] pad;
    logic signed [63:0] pbc;
    logic        [63:0] cc;
    logic        [63:0] dd;
  } st1_t;

  // after the adder stage
  typedef struct packed {
    op_t                func;
    logic signed [64:0] re;
    logic signed [64:0] im;
    logic        [63:0] den;
  } st2_t;

  // one quotient lane of the divider
  typedef struct packed {
    logic        neg;
    logic        pre_ovf;
    logic [63:0] rem;
    logic [31:0] low;
    logic [31:0] q;
  } lane_t;

  // item traveling through the divider pipe
  typedef struct packed {
    op_t                func;
    logic               dz;
    logic        [63:0] den;
    logic signed [64:0] dir_re;
    logic signed [64:0] dir_im;
    lane_t              lre;
    lane_t              lim;
  } item_t;

  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > SAT_MAX) r = {1'b1, 32'h7fffffff};
    else if (v < SAT_MIN) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/complex_arithmetic_unit_core.sv
// complex arithmetic unit: add, subtract, multiply or divide two signed fixed-point complex
// operands (FRAC_BITS fraction bits), one transaction per cycle while not stalled, fully
// pipelined through 36 register stages, the last being the output register; each stage holds
// its transaction only while the stage behind it is full and stalled, so bubbles close up and
// the input keeps flowing while a result waits, until the pipe is full. the 32 stages of the
// restoring divider, one quotient bit each, set the depth. products round toward minus
// infinity, quotients truncate toward zero, results saturate with overflow, a zero divisor
// gives zero with div_zero.
`default_nettype none
`include "complex_arithmetic_unit_core_macros.svh"
module complex_arithmetic_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [31:0] in_a_re,
  input  wire logic signed [31:0] in_a_im,
  input  wire logic signed [31:0] in_b_re,
  input  wire logic signed [31:0] in_b_im,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_res_re,
  output logic signed [31:0]      out_res_im,
  output logic                    out_overflow,
  output logic                    out_div_zero
);

  localparam int NDIV = cau_pkg::QBITS;

  // stage 1: products and add/sub sums, stage 2: sums, stage 3: rescale and divider setup
  cau_pkg::st1_t  st1_nxt, s1_r;
  cau_pkg::st2_t  st2_nxt, s2_r;
  cau_pkg::item_t it3_nxt, s3_r;
  logic           v1_r, v2_r, v3_r;
  logic           rdy1, rdy2, rdy3, rdy_out;

  // divider pipe, one quotient bit per stage
  cau_pkg::item_t dd_r   [NDIV];
  cau_pkg::item_t dd_nxt [NDIV];
  logic [NDIV-1:0] dv_r;
  logic [NDIV-1:0] rdy_d;

  logic [31:0] res_re_nxt, res_im_nxt;
  logic        ovf_nxt, dz_nxt;
  logic        out_valid_r;
  logic [31:0] out_re_r, out_im_r;
  logic        out_ovf_r, out_dz_r;

  // ready chain from the output back: a stage may load when empty or when it moves on
  assign rdy_out = !out_valid_r || !out_stall;
  always_comb begin
    rdy_d[NDIV-1] = !dv_r[NDIV-1] || rdy_out;
    for (int k = NDIV - 2; k >= 0; k--) begin
      rdy_d[k] = !dv_r[k] || rdy_d[k+1];
    end
  end
  assign rdy3     = !v3_r || rdy_d[0];
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  cau_front u_front (
    .func (in_func),
    .a_re (in_a_re),
    .a_im (in_a_im),
    .b_re (in_b_re),
    .b_im (in_b_im),
    .st1  (st1_nxt)
  );

  // adder stage: combine products per operation, add/sub pass their sums
  always_comb begin
    st2_nxt.func = s1_r.func;
    st2_nxt.den  = s1_r.cc + s1_r.dd;
    case (s1_r.func)
      cau_pkg::OP_MUL: begin
        st2_nxt.re = 65'(s1_r.pac) - 65'(s1_r.pbd);
        st2_nxt.im = 65'(s1_r.pad) + 65'(s1_r.pbc);
      end
      cau_pkg::OP_DIV: begin
        st2_nxt.re = 65'(s1_r.pac) + 65'(s1_r.pbd);
        st2_nxt.im = 65'(s1_r.pbc) - 65'(s1_r.pad);
      end
      default: begin
        st2_nxt.re = 65'(s1_r.sum_re);
        st2_nxt.im = 65'(s1_r.sum_im);
      end
    endcase
  end

  cau_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .st2  (s2_r),
    .item (it3_nxt)
  );

  cau_div_step u_step0 (
    .d_in  (s3_r),
    .d_out (dd_nxt[0])
  );

  for (genvar g = 1; g < NDIV; g++) begin : g_div
    cau_div_step u_step (
      .d_in  (dd_r[g-1]),
      .d_out (dd_nxt[g])
    );
  end

  cau_sat u_sat (
    .item     (dd_r[NDIV-1]),
    .res_re   (res_re_nxt),
    .res_im   (res_im_nxt),
    .overflow (ovf_nxt),
    .div_zero (dz_nxt)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy_d[0]) dv_r[0] <= v3_r;
      for (int k = 1; k < NDIV; k++) begin
        if (rdy_d[k]) dv_r[k] <= dv_r[k-1];
      end
      if (rdy_out) out_valid_r <= dv_r[NDIV-1];
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (rdy1) s1_r <= st1_nxt;
    if (rdy2) s2_r <= st2_nxt;
    if (rdy3) s3_r <= it3_nxt;
    for (int k = 0; k < NDIV; k++) begin
      if (rdy_d[k]) dd_r[k] <= dd_nxt[k];
    end
    if (rdy_out) begin
      out_re_r  <= res_re_nxt;
      out_im_r  <= res_im_nxt;
      out_ovf_r <= ovf_nxt;
      out_dz_r  <= dz_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_res_re   = out_re_r;
  assign out_res_im   = out_im_r;
  assign out_overflow = out_ovf_r;
  assign out_div_zero = out_dz_r;

  // an empty first stage never holds off the input
  `CAU_ASSERT(a_empty_ready, !v1_r |-> !in_stall, "input stalled with empty first stage")
  // zero divisor gives a clean zero result
  `CAU_ASSERT(a_dz_zero,
    out_valid && out_div_zero |->
      (out_res_re == 32'd0 && out_res_im == 32'd0 && !out_overflow),
    "div_zero result not zero")
  // a saturated result holds a rail in at least one part
  `CAU_ASSERT(a_ovf_rail,
    out_valid && out_overflow |->
      (out_res_re == 32'h7fffffff || out_res_re == 32'h80000000 ||
       out_res_im == 32'h7fffffff || out_res_im == 32'h80000000),
    "overflow without saturated part")

endmodule
`default_nettype wire

### rtl/cau_front.sv
`default_nettype none
module cau_front (
  input  wire logic [1:0]         func,
  input  wire logic signed [31:0] a_re,
  input  wire logic signed [31:0] a_im,
  input  wire logic signed [31:0] b_re,
  input  wire logic signed [31:0] b_im,
  output cau_pkg::st1_t           st1
);

  always_comb begin
    st1.func   = cau_pkg::op_t'(func);
    st1.sum_re = (cau_pkg::op_t'(func) == cau_pkg::OP_SUB) ?
                 (33'(a_re) - 33'(b_re)) : (33'(a_re) + 33'(b_re));
    st1.sum_im = (cau_pkg::op_t'(func) == cau_pkg::OP_SUB) ?
                 (33'(a_im) - 33'(b_im)) : (33'(a_im) + 33'(b_im));
    st1.pac    = 64'(a_re) * 64'(b_re);
    st1.pbd    = 64'(a_im) * 64'(b_im);
    st1.pad    = 64'(a_re) * 64'(b_im);
    st1.pbc    = 64'(a_im) * 64'(b_re);
    st1.cc     = $unsigned(64'(b_re) * 64'(b_re));
    st1.dd     = $unsigned(64'(b_im) * 64'(b_im));
  end

endmodule
`default_nettype wire

### rtl/cau_prep.sv
`default_nettype none
module cau_prep #(
  parameter int FRAC_BITS = 16
) (
  input  wire cau_pkg::st2_t st2,
  output cau_pkg::item_t     item
);

  logic [63:0]                mag_re, mag_im;
  logic [cau_pkg::NUM_W-1:0]  num_re, num_im;

  always_comb begin
    mag_re = st2.re[64] ? 64'(-st2.re) : st2.re[63:0];
    mag_im = st2.im[64] ? 64'(-st2.im) : st2.im[63:0];
    num_re = cau_pkg::NUM_W'(mag_re) << FRAC_BITS;
    num_im = cau_pkg::NUM_W'(mag_im) << FRAC_BITS;

    item.func = st2.func;
    item.den  = st2.den;
    item.dz   = (st2.den == 64'd0);
    // multiply rescales by an arithmetic shift, add/sub pass through
    if (st2.func == cau_pkg::OP_MUL) begin
      item.dir_re = st2.re >>> FRAC_BITS;
      item.dir_im = st2.im >>> FRAC_BITS;
    end else begin
      item.dir_re = st2.re;
      item.dir_im = st2.im;
    end

    // quotient of 2^32 or more always saturates
    item.lre.neg     = st2.re[64];
    item.lre.pre_ovf = 64'(num_re[cau_pkg::NUM_W-1:32]) >= st2.den;
    item.lre.rem     = 64'(num_re[cau_pkg::NUM_W-1:32]);
    item.lre.low     = num_re[31:0];
    item.lre.q       = '0;
    item.lim.neg     = st2.im[64];
    item.lim.pre_ovf = 64'(num_im[cau_pkg::NUM_W-1:32]) >= st2.den;
    item.lim.rem     = 64'(num_im[cau_pkg::NUM_W-1:32]);
    item.lim.low     = num_im[31:0];
    item.lim.q       = '0;
  end

endmodule
`default_nettype wire

### rtl/cau_div_step.sv
`default_nettype none
module cau_div_step (
  input  wire cau_pkg::item_t d_in,
  output cau_pkg::item_t      d_out
);

  function automatic cau_pkg::lane_t step(input cau_pkg::lane_t l, input logic [63:0] den);
    cau_pkg::lane_t r;
    logic [63:0]    t;
    logic           take;
    t     = {l.rem[62:0], l.low[31]};
    take  = (t >= den);
    r     = l;
    r.rem = take ? (t - den) : t;
    r.low = {l.low[30:0], 1'b0};
    r.q   = {l.q[30:0], take};
    return r;
  endfunction

  always_comb begin
    d_out     = d_in;
    d_out.lre = step(d_in.lre, d_in.den);
    d_out.lim = step(d_in.lim, d_in.den);
  end

endmodule
`default_nettype wire

### rtl/cau_sat.sv
`default_nettype none
module cau_sat (
  input  wire cau_pkg::item_t  item,
  output logic [31:0]          res_re,
  output logic [31:0]          res_im,
  output logic                 overflow,
  output logic                 div_zero
);

  logic [32:0] s_re, s_im;

  function automatic logic [32:0] lane_sat(input cau_pkg::lane_t l);
    logic signed [65:0] v;
    logic [32:0]        r;
    v = l.neg ? -$signed({34'd0, l.q}) : $signed({34'd0, l.q});
    if (l.pre_ovf) r = l.neg ? {1'b1, 32'h80000000} : {1'b1, 32'h7fffffff};
    else r = cau_pkg::sat32(v);
    return r;
  endfunction

  always_comb begin
    if (item.func == cau_pkg::OP_DIV) begin
      s_re = lane_sat(item.lre);
      s_im = lane_sat(item.lim);
    end else begin
      s_re = cau_pkg::sat32(66'(item.dir_re));
      s_im = cau_pkg::sat32(66'(item.dir_im));
    end
    if (item.func == cau_pkg::OP_DIV && item.dz) begin
      res_re   = '0;
      res_im   = '0;
      overflow = 1'b0;
      div_zero = 1'b1;
    end else begin
      res_re   = s_re[31:0];
      res_im   = s_im[31:0];
      overflow = s_re[32] | s_im[32];
      div_zero = 1'b0;
    end
  end

endmodule
`default_nettype wire

### tb/complex_arithmetic_unit_core_test.sv
`timescale 1ns / 100ps
`default_nettype none
module complex_arithmetic_unit_core_test;

  // pipeline depth from acceptance to result register
  localparam int LATENCY = 36;
  // cycles with no transaction on either side before giving up
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic               dz;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic signed [31:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_res_re, out_res_im;
  logic out_overflow, out_div_zero;

  cplx_res_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_ovf = 0;
  int n_dz = 0;
  int idle_cycles = 0;
  // sender burst shaping
  int burst_left = 0;
  // long receiver hold-off request
  int hold_cycles = 0;
  bit noisy_rx = 1'b1;

  always #4 clk = ~clk;

  complex_arithmetic_unit_core #(.FRAC_BITS(16)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_overflow(out_overflow), .out_div_zero(out_div_zero)
  );

  // clamp a wide signed value to 32 bits, flag when clamped
  function automatic logic signed [31:0] clamp32(input logic signed [159:0] v,
                                                 inout logic ovf);
    if (v > 160'sd2147483647) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -160'sd2147483648) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // quotient truncated toward zero
  function automatic logic signed [159:0] div_trunc(input logic signed [159:0] n,
                                                    input logic signed [159:0] d);
    logic signed [159:0] m;
    logic signed [159:0] q;
    m = (n < 0) ? -n : n;
    q = m / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t complex_result(input cau_pkg::op_t op,
      input logic signed [31:0] a, b, c, d);
    cplx_res_t r;
    logic signed [159:0] wa, wb, wc, wd, re, im, den;
    logic ovf;
    wa = a; wb = b; wc = c; wd = d;
    ovf = 1'b0;
    r = '0;
    case (op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        re = (op == cau_pkg::OP_ADD) ? wa + wc : wa - wc;
        im = (op == cau_pkg::OP_ADD) ? wb + wd : wb - wd;
        r.re = clamp32(re, ovf);
        r.im = clamp32(im, ovf);
      end
      cau_pkg::OP_MUL: begin
        re = (wa * wc - wb * wd) >>> 16;
        im = (wa * wd + wb * wc) >>> 16;
        r.re = clamp32(re, ovf);
        r.im = clamp32(im, ovf);
      end
      default: begin
        den = wc * wc + wd * wd;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          re = (wa * wc + wb * wd) <<< 16;
          im = (wb * wc - wa * wd) <<< 16;
          r.re = clamp32(div_trunc(re, den), ovf);
          r.im = clamp32(div_trunc(im, den), ovf);
        end
      end
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  // offer one transaction, predict it, wait for acceptance; random gaps between bursts
  // valid stays high after acceptance so the next transaction can follow directly
  task automatic send_op(input cau_pkg::op_t op, input logic signed [31:0] a, b, c, d,
                         input bit gaps = 1'b1);
    if (gaps) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_func <= op;
    in_a_re <= a; in_a_im <= b; in_b_re <= c; in_b_im <= d;
    pending_results.push_back(complex_result(op, a, b, c, d));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // sender goes idle and waits for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random operand with a bias toward interesting values
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 65535)) - 32768;
      4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      5: return 32'sd65536;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] mx, mn;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    send_op(cau_pkg::OP_ADD, 32'sd65536, 32'sd131072, 32'sd65536, -32'sd65536);
    send_op(cau_pkg::OP_SUB, 32'sd65536, 32'sd131072, -32'sd65536, 32'sd5);
    send_op(cau_pkg::OP_MUL, 32'sd131072, 32'sd65536, 32'sd196608, -32'sd65536);
    send_op(cau_pkg::OP_DIV, 32'sd65536, 32'sd65536, 32'sd65536, -32'sd65536);
    // saturation on add and subtract
    send_op(cau_pkg::OP_ADD, mx, mn, mx, mn);
    send_op(cau_pkg::OP_SUB, mn, mx, mx, mn);
    send_op(cau_pkg::OP_ADD, mx, mx, 32'sd0, 32'sd0);
    // multiply extremes
    send_op(cau_pkg::OP_MUL, mn, mn, mn, mn);
    send_op(cau_pkg::OP_MUL, mx, mx, mx, mn);
    send_op(cau_pkg::OP_MUL, -32'sd1, 32'sd0, 32'sd1, 32'sd0);
    send_op(cau_pkg::OP_MUL, -32'sd1, -32'sd1, 32'sd1, -32'sd1);
    // zero divisor
    send_op(cau_pkg::OP_DIV, mx, mn, 32'sd0, 32'sd0);
    send_op(cau_pkg::OP_DIV, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    // divide extremes and truncation toward zero
    send_op(cau_pkg::OP_DIV, mx, mx, 32'sd1, 32'sd0);
    send_op(cau_pkg::OP_DIV, mn, mn, 32'sd0, 32'sd1);
    send_op(cau_pkg::OP_DIV, mn, mx, mn, mn);
    send_op(cau_pkg::OP_DIV, -32'sd65536, 32'sd0, 32'sd196608, 32'sd0);
    send_op(cau_pkg::OP_DIV, 32'sd65536, -32'sd1, mx, mx);
    send_op(cau_pkg::OP_DIV, 32'sd1, 32'sd1, mn, 32'sd0);
    send_op(cau_pkg::OP_SUB, 32'sd0, 32'sd0, mn, mn);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    logic [1:0] f;
    for (int i = 0; i < count; i++) begin
      f = $urandom_range(0, 3);
      send_op(cau_pkg::op_t'(f), pick_operand(), pick_operand(), pick_operand(),
              pick_operand());
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps going until the input stalls
  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 80; i++)
      send_op(cau_pkg::op_t'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
              $urandom(), 1'b0);
    wait_drained();
  endtask

  // back-to-back with no stalls from either side
  task automatic test_streaming();
    noisy_rx = 1'b0;
    for (int i = 0; i < 100; i++)
      send_op(cau_pkg::op_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
              pick_operand(), pick_operand(), 1'b0);
    wait_drained();
    noisy_rx = 1'b1;
  endtask

  // receiver stall pattern: random stretches, or a long counted hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (!noisy_rx) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    cplx_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, out_res_re, out_res_im);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        n_checked++;
        if (exp_r.ovf) n_ovf++;
        if (exp_r.dz) n_dz++;
        if (out_res_re !== exp_r.re) begin
          $display("%0t: res_re expected %h actual %h", $time, exp_r.re, out_res_re);
          errors++;
        end
        if (out_res_im !== exp_r.im) begin
          $display("%0t: res_im expected %h actual %h", $time, exp_r.im, out_res_im);
          errors++;
        end
        if (out_overflow !== exp_r.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, out_overflow);
          errors++;
        end
        if (out_div_zero !== exp_r.dz) begin
          $display("%0t: div_zero expected %b actual %b", $time, exp_r.dz, out_div_zero);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL complex_arithmetic_unit_core");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(800);
    test_streaming();
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("covered %0d transactions sent, %0d checked, %0d saturated, %0d zero divisors",
             n_sent, n_checked, n_ovf, n_dz);
    if (errors == 0) begin
      $display("PASS complex_arithmetic_unit_core");
    end else begin
      $display("FAIL complex_arithmetic_unit_core");
    end
    $finish;
  end
endmodule
`default_nettype wire
